@@ design/accel_mag_orientation_angles_top_defines.svh @@
// Assertion macros shared by the orientation angles checker.
// Users need clk and arst_n in scope where these macros are expanded.
`ifndef ACCEL_MAG_ORIENTATION_ANGLES_TOP_DEFINES_SVH
`define ACCEL_MAG_ORIENTATION_ANGLES_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AMOA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define AMOA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/amoa_pkg.sv @@
// Package for the orientation angles block: widths, payload types, lane side data,
// the arctangent table and the angle finishing helpers. Depends on nothing.
package amoa_pkg;

	localparam int ANGLE_FRAC_BITS = 7;
	localparam int CORDIC_STAGES   = 16;

	localparam int ACC_Q      = 24;
	localparam int IN_W       = 16;
	localparam int SQ_W       = 32;
	localparam int DOT_W      = 33;
	localparam int PROD_W     = 49;
	localparam int OP_W       = 50;
	localparam int POS_W      = $clog2(OP_W);
	localparam int NORM_MSB   = 29;
	localparam int CW         = 33;
	localparam int QW         = 34;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int ROOT_W     = SQRT_STEPS;
	localparam int REM_W      = ROOT_W + 2;
	localparam int IDX_W      = $clog2(CORDIC_STAGES);
	localparam int TABLE_LEN  = 24;
	localparam int TAB_IDX_W  = $clog2(TABLE_LEN);
	localparam int ROLL_W     = 15;
	localparam int PITCH_W    = 16;
	localparam int YAW_W      = 16;
	localparam int SH         = ACC_Q - ANGLE_FRAC_BITS;

	localparam logic signed [QW-1:0] QUARTER_Q = QW'(64'sd90 <<< ACC_Q);
	localparam logic signed [QW-1:0] HALF_Q    = QW'(64'sd180 <<< ACC_Q);
	localparam logic [QW-1:0]        RND_Q     = QW'(64'd1 << (SH - 1));

	// atan(2^-i) in degrees with 24 fraction bits.
	localparam logic [30:0] ATAN_TAB [TABLE_LEN] = '{
		31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
		31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
		31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
		31'd234684,    31'd117342,    31'd58671,     31'd29335,
		31'd14668,     31'd7334,      31'd3667,      31'd1833,
		31'd917,       31'd458,       31'd229,       31'd115
	};

	typedef struct packed {
		logic signed [IN_W-1:0] accel_x;
		logic signed [IN_W-1:0] accel_y;
		logic signed [IN_W-1:0] accel_z;
		logic signed [IN_W-1:0] mag_x;
		logic signed [IN_W-1:0] mag_y;
		logic signed [IN_W-1:0] mag_z;
	} sample_t;

	typedef struct packed {
		logic signed [ROLL_W-1:0]  roll_angle;
		logic signed [PITCH_W-1:0] pitch_angle;
		logic signed [YAW_W-1:0]   yaw_angle;
		logic                      degenerate;
	} angles_t;

	// How the quadrant angle of a lane is formed.
	typedef enum logic [1:0] {
		QM_CORDIC  = 2'd0,
		QM_ZERO    = 2'd1,
		QM_QUARTER = 2'd2,
		QM_NONE    = 2'd3
	} qmode_t;

	typedef struct packed {
		qmode_t mode;
		logic   xneg;
		logic   yneg;
		logic   degen;
	} lane_side_t;

	function automatic logic [QW-1:0] atan_entry(input logic [IDX_W-1:0] idx);
		return QW'(ATAN_TAB[TAB_IDX_W'(idx)]);
	endfunction

	// Position of the highest set bit; zero for a zero word.
	function automatic logic [POS_W-1:0] msb_pos(input logic [OP_W-1:0] v);
		logic [POS_W-1:0] p;
		p = '0;
		for (int i = 0; i < OP_W; i++) begin
			if (v[i]) begin
				p = POS_W'(i);
			end
		end
		return p;
	endfunction

	// Clamp, restore the quadrant, round half up and apply the sign; zero if degenerate or QM_NONE.
	function automatic logic signed [QW-1:0] finish_angle(input logic signed [QW-1:0] q,
			input lane_side_t s);
		logic signed [QW-1:0] qc;
		logic [QW-1:0]        r;
		case (s.mode)
			QM_CORDIC: begin
				if (q < 0) begin
					qc = '0;
				end else if (q > QUARTER_Q) begin
					qc = QUARTER_Q;
				end else begin
					qc = q;
				end
			end
			QM_QUARTER: begin
				qc = QUARTER_Q;
			end
			default: begin
				qc = '0;
			end
		endcase
		if (s.xneg) begin
			qc = HALF_Q - qc;
		end
		r = (unsigned'(qc) + RND_Q) >> SH;
		if (s.degen || (s.mode == QM_NONE)) begin
			return '0;
		end
		return s.yneg ? -signed'(r) : signed'(r);
	endfunction

	// Saturate to a signed field of w bits, returned in 16 bits.
	function automatic logic signed [15:0] sat_angle(input logic signed [QW-1:0] v, input int w);
		logic signed [QW-1:0] hi;
		logic signed [QW-1:0] lo;
		hi = QW'((64'sd1 <<< (w - 1)) - 64'sd1);
		lo = -hi - QW'(1);
		if (v > hi) begin
			return 16'(hi);
		end else if (v < lo) begin
			return 16'(lo);
		end
		return 16'(v);
	endfunction

endpackage

@@ design/amoa_sqrt_cell.sv @@
// One cell of the floor square root chain: one root bit per cell.
// Depends on amoa_pkg.
module amoa_sqrt_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [amoa_pkg::SQ_W-1:0]    n_in,
	input  logic [amoa_pkg::REM_W-1:0]   rem_in,
	input  logic [amoa_pkg::ROOT_W-1:0]  root_in,
	output logic [amoa_pkg::SQ_W-1:0]    n_q,
	output logic [amoa_pkg::REM_W-1:0]   rem_q,
	output logic [amoa_pkg::ROOT_W-1:0]  root_q
);

	logic [amoa_pkg::REM_W+1:0] acc;
	logic [amoa_pkg::REM_W+1:0] trial;
	logic                       take;

	// Bring down the next two radicand bits and try root*4+1.
	always_comb begin
		acc   = {rem_in, n_in[amoa_pkg::SQ_W-1 -: 2]};
		trial = (amoa_pkg::REM_W + 2)'({root_in, 2'b01});
		take  = (acc >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q    <= {n_in[amoa_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= take ? amoa_pkg::REM_W'(acc - trial) : amoa_pkg::REM_W'(acc);
			root_q <= {root_in[amoa_pkg::ROOT_W-2:0], take};
		end
	end

endmodule

@@ design/amoa_norm.sv @@
// Operand conditioning for one arctangent lane: magnitudes, quadrant flags and the
// shift that puts the larger magnitude in [2^29, 2^30). Two stages. Depends on amoa_pkg.
module amoa_norm (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [amoa_pkg::OP_W-1:0]  y_in,
	input  logic signed [amoa_pkg::OP_W-1:0]  x_in,
	input  logic                              degen_in,
	output logic signed [amoa_pkg::CW-1:0]    x_s2,
	output logic signed [amoa_pkg::CW-1:0]    y_s2,
	output amoa_pkg::lane_side_t              side_s2
);

	logic [amoa_pkg::OP_W-1:0]  ux;
	logic [amoa_pkg::OP_W-1:0]  uy;
	amoa_pkg::lane_side_t       side;
	logic [amoa_pkg::OP_W-1:0]  ux_s1;
	logic [amoa_pkg::OP_W-1:0]  uy_s1;
	logic [amoa_pkg::POS_W-1:0] pos_s1;
	amoa_pkg::lane_side_t       side_s1;
	logic [amoa_pkg::POS_W-1:0] shr;
	logic [amoa_pkg::POS_W-1:0] shl;
	logic [amoa_pkg::OP_W-1:0]  xn;
	logic [amoa_pkg::OP_W-1:0]  yn;

	always_comb begin
		ux = x_in[amoa_pkg::OP_W-1] ? unsigned'(-x_in) : unsigned'(x_in);
		uy = y_in[amoa_pkg::OP_W-1] ? unsigned'(-y_in) : unsigned'(y_in);
		side.xneg  = x_in[amoa_pkg::OP_W-1];
		side.yneg  = y_in[amoa_pkg::OP_W-1];
		side.degen = degen_in;
		if ((x_in == '0) && (y_in == '0)) begin
			side.mode = amoa_pkg::QM_NONE;
		end else if (y_in == '0) begin
			side.mode = amoa_pkg::QM_ZERO;
		end else if (x_in == '0) begin
			side.mode = amoa_pkg::QM_QUARTER;
		end else begin
			side.mode = amoa_pkg::QM_CORDIC;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1   <= ux;
			uy_s1   <= uy;
			pos_s1  <= amoa_pkg::msb_pos(ux | uy);
			side_s1 <= side;
		end
	end

	// Right shifts truncate both magnitudes alike; left shifts are exact.
	always_comb begin
		shr = pos_s1 - amoa_pkg::POS_W'(amoa_pkg::NORM_MSB);
		shl = amoa_pkg::POS_W'(amoa_pkg::NORM_MSB) - pos_s1;
		if (pos_s1 > amoa_pkg::POS_W'(amoa_pkg::NORM_MSB)) begin
			xn = ux_s1 >> shr;
			yn = uy_s1 >> shr;
		end else begin
			xn = ux_s1 << shl;
			yn = uy_s1 << shl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2    <= signed'(amoa_pkg::CW'(xn));
			y_s2    <= signed'(amoa_pkg::CW'(yn));
			side_s2 <= side_s1;
		end
	end

endmodule

@@ design/amoa_cordic_cell.sv @@
// One vectoring CORDIC cell: one micro-rotation and its angle step per cycle while en is high.
// Depends on amoa_pkg.
module amoa_cordic_cell (
	input  logic                             clk,
	input  logic                             en,
	input  logic [amoa_pkg::IDX_W-1:0]       stage,
	input  logic signed [amoa_pkg::CW-1:0]   x_in,
	input  logic signed [amoa_pkg::CW-1:0]   y_in,
	input  logic signed [amoa_pkg::QW-1:0]   q_in,
	input  amoa_pkg::lane_side_t             side_in,
	output logic signed [amoa_pkg::CW-1:0]   x_q,
	output logic signed [amoa_pkg::CW-1:0]   y_q,
	output logic signed [amoa_pkg::QW-1:0]   q_q,
	output amoa_pkg::lane_side_t             side_q
);

	logic signed [amoa_pkg::CW-1:0] dx;
	logic signed [amoa_pkg::CW-1:0] dy;
	logic signed [amoa_pkg::QW-1:0] step;

	// Arithmetic shifts round toward minus infinity.
	always_comb begin
		dx   = y_in >>> stage;
		dy   = x_in >>> stage;
		step = signed'(amoa_pkg::atan_entry(stage));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[amoa_pkg::CW-1]) begin
				x_q <= x_in + dx;
				y_q <= y_in - dy;
				q_q <= q_in + step;
			end else begin
				x_q <= x_in - dx;
				y_q <= y_in + dy;
				q_q <= q_in - step;
			end
			side_q <= side_in;
		end
	end

endmodule

@@ design/accel_mag_orientation_angles_top.sv @@
// Top level of the orientation angles block: products, square root chain, three
// arctangent lanes and the result register. Depends on amoa_pkg and the cell modules.
//
// The block takes one accelerometer and magnetometer request per cycle and returns
// roll, pitch and yaw in degrees with ANGLE_FRAC_BITS fraction bits, plus a flag for an
// all-zero accelerometer vector (angles then read zero). Every request gives exactly
// one result, in order. A new request is taken in every cycle in which the result
// register is empty or its result is being taken; sample_stall rises only while a
// finished result waits under angle_stall, and the whole pipeline then holds. A request
// passes through the registered products and sums, sixteen cells of the bit-per-cell
// floor square root of ax^2+az^2 (the magnetometer cross products finish alongside),
// the registered operand normalization, one CORDIC cell per stage in each of the three
// lanes, and the rounding and saturation into the result register.
module accel_mag_orientation_angles_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  amoa_pkg::sample_t sample,
	output logic              angle_valid,
	input  logic              angle_stall,
	output amoa_pkg::angles_t angle
);

	localparam int N_SQ  = amoa_pkg::SQRT_STEPS;
	localparam int N_CR  = amoa_pkg::CORDIC_STAGES;
	localparam int DEPTH = 2 + N_SQ + 2 + N_CR + 1;
	localparam int LANES = 3;

	// Data that rides beside the square root chain.
	typedef struct packed {
		logic signed [amoa_pkg::IN_W-1:0]   ay;
		logic signed [amoa_pkg::IN_W:0]     nax;
		logic signed [amoa_pkg::IN_W-1:0]   az;
		logic signed [amoa_pkg::PROD_W-1:0] pa;
		logic signed [amoa_pkg::PROD_W-1:0] pb;
		logic signed [amoa_pkg::PROD_W-1:0] pc;
		logic signed [amoa_pkg::PROD_W-1:0] pd;
		logic signed [amoa_pkg::OP_W-1:0]   ex;
		logic signed [amoa_pkg::OP_W-1:0]   ey;
		logic                               degen;
	} mid_t;

	logic             adv;
	logic [DEPTH-1:0] vld_q;

	// The pipeline moves as one whenever the result register can take a new value.
	assign adv          = !vld_q[DEPTH-1] || !angle_stall;
	assign sample_stall = !adv;
	assign angle_valid  = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[DEPTH-2:0], sample_valid};
		end
	end

	// Stage 1: squares of the accelerometer and the terms of the dot product.
	logic signed [amoa_pkg::SQ_W-1:0] sxx;
	logic signed [amoa_pkg::SQ_W-1:0] syy;
	logic signed [amoa_pkg::SQ_W-1:0] szz;
	logic signed [amoa_pkg::SQ_W-1:0] dxx;
	logic signed [amoa_pkg::SQ_W-1:0] dyy;
	logic signed [amoa_pkg::SQ_W-1:0] dzz;

	assign sxx = sample.accel_x * sample.accel_x;
	assign syy = sample.accel_y * sample.accel_y;
	assign szz = sample.accel_z * sample.accel_z;
	assign dxx = sample.mag_x * sample.accel_x;
	assign dyy = sample.mag_y * sample.accel_y;
	assign dzz = sample.mag_z * sample.accel_z;

	logic signed [amoa_pkg::SQ_W-1:0] sxx_s1;
	logic signed [amoa_pkg::SQ_W-1:0] syy_s1;
	logic signed [amoa_pkg::SQ_W-1:0] szz_s1;
	logic signed [amoa_pkg::SQ_W-1:0] dxx_s1;
	logic signed [amoa_pkg::SQ_W-1:0] dyy_s1;
	logic signed [amoa_pkg::SQ_W-1:0] dzz_s1;
	amoa_pkg::sample_t                smp_s1;
	logic                             degen_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sxx_s1   <= sxx;
			syy_s1   <= syy;
			szz_s1   <= szz;
			dxx_s1   <= dxx;
			dyy_s1   <= dyy;
			dzz_s1   <= dzz;
			smp_s1   <= sample;
			degen_s1 <= (sample.accel_x == '0) && (sample.accel_y == '0) &&
				(sample.accel_z == '0);
		end
	end

	// Stage 2: ax^2+az^2, the squared norm a.a and the dot product m.a.
	logic [amoa_pkg::SQ_W-1:0]         sxz;
	logic [amoa_pkg::SQ_W-1:0]         sxz_s2;
	logic [amoa_pkg::SQ_W-1:0]         norm_s2;
	logic signed [amoa_pkg::DOT_W-1:0] dot_s2;
	amoa_pkg::sample_t                 smp_s2;
	logic                              degen_s2;

	assign sxz = unsigned'(sxx_s1) + unsigned'(szz_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			sxz_s2   <= sxz;
			norm_s2  <= sxz + unsigned'(syy_s1);
			dot_s2   <= amoa_pkg::DOT_W'(dxx_s1) + amoa_pkg::DOT_W'(dyy_s1) +
				amoa_pkg::DOT_W'(dzz_s1);
			smp_s2   <= smp_s1;
			degen_s2 <= degen_s1;
		end
	end

	// Square root chain of ax^2+az^2.
	logic [amoa_pkg::SQ_W-1:0]   sq_n    [N_SQ+1];
	logic [amoa_pkg::REM_W-1:0]  sq_rem  [N_SQ+1];
	logic [amoa_pkg::ROOT_W-1:0] sq_root [N_SQ+1];

	assign sq_n[0]    = sxz_s2;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < N_SQ; k++) begin : g_sqrt
		amoa_sqrt_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.n_in    (sq_n[k]),
			.rem_in  (sq_rem[k]),
			.root_in (sq_root[k]),
			.n_q     (sq_n[k+1]),
			.rem_q   (sq_rem[k+1]),
			.root_q  (sq_root[k+1])
		);
	end

	// Side line: the cross products enter in its first stage and the rejected
	// magnetic vector (a.a)m - (m.a)a is formed in its second.
	logic signed [amoa_pkg::PROD_W-1:0] pa;
	logic signed [amoa_pkg::PROD_W-1:0] pb;
	logic signed [amoa_pkg::PROD_W-1:0] pc;
	logic signed [amoa_pkg::PROD_W-1:0] pd;
	mid_t                               mid0;
	mid_t                               mid1;
	mid_t                               mid_q [N_SQ];

	assign pa = smp_s2.mag_x * $signed({1'b0, norm_s2});
	assign pb = smp_s2.accel_x * dot_s2;
	assign pc = smp_s2.mag_y * $signed({1'b0, norm_s2});
	assign pd = smp_s2.accel_y * dot_s2;

	always_comb begin
		mid0       = '0;
		mid0.ay    = smp_s2.accel_y;
		mid0.nax   = -((amoa_pkg::IN_W + 1)'(smp_s2.accel_x));
		mid0.az    = smp_s2.accel_z;
		mid0.pa    = pa;
		mid0.pb    = pb;
		mid0.pc    = pc;
		mid0.pd    = pd;
		mid0.degen = degen_s2;
		mid1       = mid_q[0];
		mid1.ex    = amoa_pkg::OP_W'(mid_q[0].pa) - amoa_pkg::OP_W'(mid_q[0].pb);
		mid1.ey    = amoa_pkg::OP_W'(mid_q[0].pc) - amoa_pkg::OP_W'(mid_q[0].pd);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mid_q[0] <= mid0;
			mid_q[1] <= mid1;
			for (int k = 2; k < N_SQ; k++) begin
				mid_q[k] <= mid_q[k-1];
			end
		end
	end

	// Lane operands: roll = atan2(ay, root), pitch = atan2(-ax, az), yaw = atan2(ex, ey).
	logic signed [amoa_pkg::OP_W-1:0] lane_y [LANES];
	logic signed [amoa_pkg::OP_W-1:0] lane_x [LANES];

	always_comb begin
		lane_y[0] = amoa_pkg::OP_W'(mid_q[N_SQ-1].ay);
		lane_x[0] = signed'(amoa_pkg::OP_W'(sq_root[N_SQ]));
		lane_y[1] = amoa_pkg::OP_W'(mid_q[N_SQ-1].nax);
		lane_x[1] = amoa_pkg::OP_W'(mid_q[N_SQ-1].az);
		lane_y[2] = mid_q[N_SQ-1].ex;
		lane_x[2] = mid_q[N_SQ-1].ey;
	end

	logic signed [amoa_pkg::CW-1:0] cx   [LANES][N_CR+1];
	logic signed [amoa_pkg::CW-1:0] cy   [LANES][N_CR+1];
	logic signed [amoa_pkg::QW-1:0] cq   [LANES][N_CR+1];
	amoa_pkg::lane_side_t           cs   [LANES][N_CR+1];

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		amoa_norm u_norm (
			.clk      (clk),
			.en       (adv),
			.y_in     (lane_y[l]),
			.x_in     (lane_x[l]),
			.degen_in (mid_q[N_SQ-1].degen),
			.x_s2     (cx[l][0]),
			.y_s2     (cy[l][0]),
			.side_s2  (cs[l][0])
		);

		assign cq[l][0] = '0;

		for (genvar k = 0; k < N_CR; k++) begin : g_stage
			amoa_cordic_cell u_cell (
				.clk     (clk),
				.en      (adv),
				.stage   (amoa_pkg::IDX_W'(k)),
				.x_in    (cx[l][k]),
				.y_in    (cy[l][k]),
				.q_in    (cq[l][k]),
				.side_in (cs[l][k]),
				.x_q     (cx[l][k+1]),
				.y_q     (cy[l][k+1]),
				.q_q     (cq[l][k+1]),
				.side_q  (cs[l][k+1])
			);
		end
	end

	// Result register: quadrant restore, rounding, sign and saturation.
	always_ff @(posedge clk) begin
		if (adv) begin
			angle.roll_angle  <= amoa_pkg::ROLL_W'(amoa_pkg::sat_angle(
				amoa_pkg::finish_angle(cq[0][N_CR], cs[0][N_CR]), amoa_pkg::ROLL_W));
			angle.pitch_angle <= amoa_pkg::PITCH_W'(amoa_pkg::sat_angle(
				amoa_pkg::finish_angle(cq[1][N_CR], cs[1][N_CR]), amoa_pkg::PITCH_W));
			angle.yaw_angle   <= amoa_pkg::YAW_W'(amoa_pkg::sat_angle(
				amoa_pkg::finish_angle(cq[2][N_CR], cs[2][N_CR]), amoa_pkg::YAW_W));
			angle.degenerate  <= cs[0][N_CR].degen;
		end
	end

	// The squared accelerometer x and z also feed the remainder chain only through sxz.

endmodule

@@ design/amoa_checker.sv @@
// Port-level checker for the orientation angles block, bound to the top level.
// Depends on amoa_pkg and accel_mag_orientation_angles_top_defines.svh.
`include "accel_mag_orientation_angles_top_defines.svh"

module amoa_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              sample_valid,
	input logic              sample_stall,
	input amoa_pkg::sample_t sample,
	input logic              angle_valid,
	input logic              angle_stall,
	input amoa_pkg::angles_t angle
);

	localparam int ROLL_LIM = 90 << amoa_pkg::ANGLE_FRAC_BITS;

	// A held result keeps its value until it is taken.
	`AMOA_ASSERT_NXT(a_hold, angle_valid && angle_stall, angle_valid && $stable(angle), "result changed while stalled")

	// Requests are refused only behind a stalled result.
	`AMOA_ASSERT_IMP(a_stall_src, sample_stall, angle_valid && angle_stall, "request stalled without output back-pressure")

	// A zero accelerometer vector gives zero angles.
	`AMOA_ASSERT_IMP(a_degen, angle_valid && angle.degenerate, (angle.roll_angle == '0) && (angle.pitch_angle == '0) && (angle.yaw_angle == '0), "degenerate result with nonzero angle")

	// Roll stays within a quarter turn.
	`AMOA_ASSERT_IMP(a_roll, angle_valid, (angle.roll_angle >= -ROLL_LIM) && (angle.roll_angle <= ROLL_LIM), "roll outside quarter turn")

endmodule

bind accel_mag_orientation_angles_top amoa_checker u_amoa_checker (.*);
